// ----- src/assert_macros.svh -----
// assertion macros shared by the checker file
// every macro samples on the rising edge of clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is low
`define KLEX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define KLEX_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/klex_pkg.sv -----
// klex_pkg: widths, token kinds and the token record of the keyword token lexer
// no dependencies; used by the channel interfaces, the lexer and its checker
`default_nettype none

package klex_pkg;

   localparam int MAX_TEXT    = 63;
   localparam int OFFSET_BITS = 24;
   localparam int LEN_BITS    = $clog2(MAX_TEXT + 1);
   localparam int LINE_BITS   = 16;
   localparam int KIND_BITS   = 5;
   localparam int BYTE_BITS   = 8;

   typedef enum logic [KIND_BITS-1:0] {
      TK_IDENT    = 5'd0,
      TK_NUMBER   = 5'd1,
      TK_STRING   = 5'd2,
      TK_FN       = 5'd3,
      TK_END      = 5'd4,
      TK_VAR      = 5'd5,
      TK_IF       = 5'd6,
      TK_ELSE     = 5'd7,
      TK_LOOP     = 5'd8,
      TK_PRINT    = 5'd9,
      TK_PRINTN   = 5'd10,
      TK_RET      = 5'd11,
      TK_ASSIGN   = 5'd12,
      TK_PLUS     = 5'd13,
      TK_MINUS    = 5'd14,
      TK_STAR     = 5'd15,
      TK_SLASH    = 5'd16,
      TK_GREATER  = 5'd17,
      TK_LESS     = 5'd18,
      TK_EQUALITY = 5'd19,
      TK_AND      = 5'd20,
      TK_OR       = 5'd21,
      TK_NEWLINE  = 5'd22,
      TK_EOF      = 5'd23
   } token_kind_type;

   typedef struct packed {
      token_kind_type         kind;
      logic [LINE_BITS-1:0]   line;
      logic [OFFSET_BITS-1:0] start;
      logic [LEN_BITS-1:0]    length;
      logic                   bad;
      logic                   last;
   } token_type;

endpackage

`default_nettype wire

// ----- src/klex_if.sv -----
// klex_req_if and klex_rsp_if: valid/ready channels of the keyword token lexer
// depends on klex_pkg for field widths
`default_nettype none

interface klex_req_if import klex_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] source_byte;
   logic                 end_of_source;

   modport source (output valid, source_byte, end_of_source, input ready);
   modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface klex_rsp_if import klex_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   token_kind;
   logic [LINE_BITS-1:0]   token_line;
   logic [OFFSET_BITS-1:0] token_start;
   logic [LEN_BITS-1:0]    token_length;
   logic                   bad_byte;
   logic                   run_last;

   modport source (output valid, token_kind, token_line, token_start, token_length,
                   bad_byte, run_last, input ready);
   modport sink   (input valid, token_kind, token_line, token_start, token_length,
                   bad_byte, run_last, output ready);
endinterface

`default_nettype wire

// ----- src/keyword_token_lexer.sv -----
// keyword_token_lexer: byte stream in, tokens out
// depends on klex_pkg and the channel interfaces in klex_if.sv
//
// Usage
//   req_bus takes one source byte per transfer, with end_of_source marking
//   the final byte of a text. rsp_bus gives tokens: kind, start line, start
//   offset, length, a flag for an unrecognised byte and run_last on the last
//   token that a byte caused. A byte may cause no token or up to three.
//   A byte is held in the input register, and its tokens are then loaded
//   into the three-entry result register, from which they are offered.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and the receiver is ready; a byte that yields more tokens holds the
//   result register until they drain, one token per cycle while the receiver
//   is ready. A new byte is taken while the last pending token is transferring.
//   Reset (synchronous) empties both registers and returns the scanner to
//   line 1, offset 0, no token open.
//   When the receiver stalls, the tokens stay in place, the byte in the
//   input register waits and req_bus.ready falls.
`default_nettype none

module keyword_token_lexer import klex_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   klex_req_if.sink      req_bus,
   klex_rsp_if.source    rsp_bus
);

   localparam int PREFIX_BYTES = 6;
   localparam int PREFIX_BITS  = PREFIX_BYTES * BYTE_BITS;
   localparam int SLOTS        = 3;

   localparam logic [BYTE_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [BYTE_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_NL      = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_BITS-1:0] CH_QUOTE   = 8'h22;
   localparam logic [BYTE_BITS-1:0] CH_HASH    = 8'h23;
   localparam logic [BYTE_BITS-1:0] CH_STAR    = 8'h2A;
   localparam logic [BYTE_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [BYTE_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CH_SLASH   = 8'h2F;
   localparam logic [BYTE_BITS-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [BYTE_BITS-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [BYTE_BITS-1:0] CH_LT      = 8'h3C;
   localparam logic [BYTE_BITS-1:0] CH_EQ      = 8'h3D;
   localparam logic [BYTE_BITS-1:0] CH_GT      = 8'h3E;
   localparam logic [BYTE_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [BYTE_BITS-1:0] CH_USCORE  = 8'h5F;
   localparam logic [BYTE_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_BITS-1:0] CH_LOWER_Z = 8'h7A;

   // keyword text, first character in the low byte
   localparam logic [PREFIX_BITS-1:0] KW_FN     = 48'h0000_0000_6E66;
   localparam logic [PREFIX_BITS-1:0] KW_END    = 48'h0000_0064_6E65;
   localparam logic [PREFIX_BITS-1:0] KW_VAR    = 48'h0000_0072_6176;
   localparam logic [PREFIX_BITS-1:0] KW_IF     = 48'h0000_0000_6669;
   localparam logic [PREFIX_BITS-1:0] KW_ELSE   = 48'h0000_6573_6C65;
   localparam logic [PREFIX_BITS-1:0] KW_LOOP   = 48'h0000_706F_6F6C;
   localparam logic [PREFIX_BITS-1:0] KW_PRINT  = 48'h0074_6E69_7270;
   localparam logic [PREFIX_BITS-1:0] KW_PRINTN = 48'h6E74_6E69_7270;
   localparam logic [PREFIX_BITS-1:0] KW_RET    = 48'h0000_0074_6572;
   localparam logic [PREFIX_BITS-1:0] KW_AND    = 48'h0000_0064_6E61;
   localparam logic [PREFIX_BITS-1:0] KW_OR     = 48'h0000_0000_726F;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_IDENT   = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_COMMENT = 3'd4,
      MODE_HALT    = 3'd5
   } mode_type;

   function automatic logic is_digit(input logic [BYTE_BITS-1:0] b);
      return (b >= CH_DIGIT_0) && (b <= CH_DIGIT_9);
   endfunction

   function automatic logic is_word_start(input logic [BYTE_BITS-1:0] b);
      return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
             ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) || (b == CH_USCORE);
   endfunction

   function automatic token_kind_type ident_kind(input logic [LEN_BITS-1:0]    len,
                                                 input logic [PREFIX_BITS-1:0] pfx);
      token_kind_type k;
      k = TK_IDENT;
      case (pfx)
         KW_FN:     if (len == LEN_BITS'(2)) k = TK_FN;
         KW_END:    if (len == LEN_BITS'(3)) k = TK_END;
         KW_VAR:    if (len == LEN_BITS'(3)) k = TK_VAR;
         KW_IF:     if (len == LEN_BITS'(2)) k = TK_IF;
         KW_ELSE:   if (len == LEN_BITS'(4)) k = TK_ELSE;
         KW_LOOP:   if (len == LEN_BITS'(4)) k = TK_LOOP;
         KW_PRINT:  if (len == LEN_BITS'(5)) k = TK_PRINT;
         KW_PRINTN: if (len == LEN_BITS'(6)) k = TK_PRINTN;
         KW_RET:    if (len == LEN_BITS'(3)) k = TK_RET;
         KW_AND:    if (len == LEN_BITS'(3)) k = TK_AND;
         KW_OR:     if (len == LEN_BITS'(2)) k = TK_OR;
         default:   k = TK_IDENT;
      endcase
      return k;
   endfunction

   function automatic token_kind_type op_kind(input logic [BYTE_BITS-1:0] b);
      token_kind_type k;
      case (b)
         CH_EQ:    k = TK_ASSIGN;
         CH_PLUS:  k = TK_PLUS;
         CH_MINUS: k = TK_MINUS;
         CH_STAR:  k = TK_STAR;
         CH_SLASH: k = TK_SLASH;
         CH_GT:    k = TK_GREATER;
         CH_LT:    k = TK_LESS;
         default:  k = TK_EOF;
      endcase
      return k;
   endfunction

   // only the first six bytes are kept for keyword matching
   function automatic logic [PREFIX_BITS-1:0] append_prefix(
         input logic [PREFIX_BITS-1:0] pfx,
         input logic [LEN_BITS-1:0]    len,
         input logic [BYTE_BITS-1:0]   b);
      logic [PREFIX_BITS-1:0] p;
      p = pfx;
      for (int i = 0; i < PREFIX_BYTES; i++) begin
         if (len == LEN_BITS'(i)) p[BYTE_BITS*i +: BYTE_BITS] = b;
      end
      return p;
   endfunction

   function automatic token_type make_token(input token_kind_type         kind,
                                            input logic [LINE_BITS-1:0]   line,
                                            input logic [OFFSET_BITS-1:0] start,
                                            input logic [LEN_BITS-1:0]    length,
                                            input logic                   bad);
      token_type t;
      t.kind   = kind;
      t.line   = line;
      t.start  = start;
      t.length = length;
      t.bad    = bad;
      t.last   = 1'b0;
      return t;
   endfunction

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_last_ff;

   // scanner state
   mode_type               mode_ff, mode_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [PREFIX_BITS-1:0] prefix_ff, prefix_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] origin_ff, origin_in;

   // result register
   token_type  slot_ff [SLOTS];
   token_type  slot_in [SLOTS];
   logic [1:0] rem_ff, rem_in;

   logic       req_xfer, rsp_xfer, advance;

   // per-byte working values
   mode_type               mode_a, mode_b;
   logic [LEN_BITS-1:0]    len_a, len_b;
   logic [PREFIX_BITS-1:0] prefix_a, prefix_b;
   logic [OFFSET_BITS-1:0] origin_b, pos_next;
   logic [LINE_BITS-1:0]   line_b;
   logic                   taken, active;
   logic                   e0_v, e1_v, e2_v, e3_v;
   token_kind_type         e0_kind, e1_kind, e2_kind;
   logic [LEN_BITS-1:0]    e1_len;
   logic                   e1_bad;
   token_type              new_slot [SLOTS];
   logic [1:0]             new_count;

   assign rsp_xfer = rsp_bus.valid && rsp_bus.ready;
   assign advance  = in_valid_ff &&
                     ((rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_bus.ready));
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // continue the open token with this byte
   always_comb begin
      mode_a   = mode_ff;
      len_a    = len_ff;
      prefix_a = prefix_ff;
      taken    = 1'b0;
      e0_v     = 1'b0;
      e0_kind  = TK_STRING;
      case (mode_ff)
         MODE_IDENT, MODE_NUMBER: begin
            if ((mode_ff == MODE_IDENT) ? (is_word_start(in_byte_ff) || is_digit(in_byte_ff))
                                        : is_digit(in_byte_ff)) begin
               taken    = 1'b1;
               len_a    = len_ff + LEN_BITS'(1);
               prefix_a = append_prefix(prefix_ff, len_ff, in_byte_ff);
               if (len_a >= LEN_BITS'(MAX_TEXT)) begin
                  e0_v   = 1'b1;
                  mode_a = MODE_IDLE;
               end
            end else begin
               e0_v   = 1'b1;
               mode_a = MODE_IDLE;
            end
            e0_kind = (mode_ff == MODE_IDENT) ? ident_kind(len_a, prefix_a) : TK_NUMBER;
         end
         MODE_STRING: begin
            if (in_byte_ff == CH_QUOTE) begin
               taken    = 1'b1;
               len_a    = len_ff + LEN_BITS'(1);
               prefix_a = append_prefix(prefix_ff, len_ff, in_byte_ff);
               e0_v     = 1'b1;
               mode_a   = MODE_IDLE;
            end else if ((in_byte_ff != CH_NUL) && (len_ff < LEN_BITS'(MAX_TEXT - 1))) begin
               taken    = 1'b1;
               len_a    = len_ff + LEN_BITS'(1);
               prefix_a = append_prefix(prefix_ff, len_ff, in_byte_ff);
            end else begin
               // string at its limit or cut short: emitted without closing quote
               e0_v   = 1'b1;
               mode_a = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            if ((in_byte_ff != CH_NL) && (in_byte_ff != CH_NUL)) taken  = 1'b1;
            else                                                mode_a = MODE_IDLE;
         end
         default: mode_a = MODE_IDLE;
      endcase
   end

   // scan the byte afresh when the open token did not take it
   always_comb begin
      mode_b   = mode_a;
      len_b    = len_a;
      prefix_b = prefix_a;
      origin_b = origin_ff;
      line_b   = line_ff;
      e1_v     = 1'b0;
      e1_kind  = TK_EOF;
      e1_len   = LEN_BITS'(1);
      e1_bad   = 1'b0;
      if (!taken) begin
         case (in_byte_ff) inside
            CH_SPACE, CH_TAB, CH_CR: begin
               // whitespace is skipped
            end
            CH_NUL: begin
               e1_v   = 1'b1;
               e1_len = '0;
               mode_b = MODE_HALT;
            end
            CH_NL: begin
               e1_v    = 1'b1;
               e1_kind = TK_NEWLINE;
               if (line_ff != '1) line_b = line_ff + LINE_BITS'(1);
            end
            CH_HASH: mode_b = MODE_COMMENT;
            CH_QUOTE: begin
               mode_b   = MODE_STRING;
               origin_b = pos_ff;
               len_b    = LEN_BITS'(1);
               prefix_b = PREFIX_BITS'(in_byte_ff);
            end
            CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GT, CH_LT: begin
               e1_v    = 1'b1;
               e1_kind = op_kind(in_byte_ff);
            end
            [CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z], CH_USCORE: begin
               mode_b   = MODE_IDENT;
               origin_b = pos_ff;
               len_b    = LEN_BITS'(1);
               prefix_b = PREFIX_BITS'(in_byte_ff);
            end
            [CH_DIGIT_0:CH_DIGIT_9]: begin
               mode_b   = MODE_NUMBER;
               origin_b = pos_ff;
               len_b    = LEN_BITS'(1);
               prefix_b = PREFIX_BITS'(in_byte_ff);
            end
            default: begin
               e1_v   = 1'b1;
               e1_len = '0;
               e1_bad = 1'b1;
               mode_b = MODE_HALT;
            end
         endcase
      end
   end

   // end of source: flush what is open, then the end token
   always_comb begin
      pos_next = pos_ff + OFFSET_BITS'(1);
      active   = (mode_ff != MODE_HALT);
      e3_v     = active && in_last_ff && (mode_b != MODE_HALT);
      e2_v     = e3_v && ((mode_b == MODE_IDENT) || (mode_b == MODE_NUMBER) ||
                          (mode_b == MODE_STRING));
      case (mode_b)
         MODE_IDENT:  e2_kind = ident_kind(len_b, prefix_b);
         MODE_NUMBER: e2_kind = TK_NUMBER;
         default:     e2_kind = TK_STRING;
      endcase
   end

   // pack the tokens of this byte into the result slots in order
   always_comb begin
      logic [1:0] n;
      n = 2'd0;
      for (int i = 0; i < SLOTS; i++) new_slot[i] = slot_ff[i];
      if (active && e0_v) begin
         new_slot[n] = make_token(e0_kind, line_ff, origin_ff, len_a, 1'b0);
         n = n + 2'd1;
      end
      // a fresh single-character token and an end-of-source flush never meet
      if (active && e1_v) begin
         new_slot[n] = make_token(e1_kind, line_ff, pos_ff, e1_len, e1_bad);
         n = n + 2'd1;
      end else if (e2_v) begin
         new_slot[n] = make_token(e2_kind, line_b, origin_b, len_b, 1'b0);
         n = n + 2'd1;
      end
      if (e3_v) begin
         new_slot[n] = make_token(TK_EOF, line_b, pos_next, '0, 1'b0);
         n = n + 2'd1;
      end
      for (int i = 0; i < SLOTS; i++) new_slot[i].last = (n == 2'(i + 1));
      new_count = n;
   end

   // next values of all registers
   always_comb begin
      in_valid_in = in_valid_ff;
      mode_in     = mode_ff;
      len_in      = len_ff;
      prefix_in   = prefix_ff;
      line_in     = line_ff;
      pos_in      = pos_ff;
      origin_in   = origin_ff;
      rem_in      = rem_ff;
      for (int i = 0; i < SLOTS; i++) slot_in[i] = slot_ff[i];

      if (req_xfer)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      if (advance) begin
         if (in_last_ff) begin
            mode_in   = MODE_IDLE;
            len_in    = '0;
            prefix_in = '0;
            line_in   = LINE_BITS'(1);
            pos_in    = '0;
            origin_in = '0;
         end else if (active) begin
            mode_in   = mode_b;
            len_in    = len_b;
            prefix_in = prefix_b;
            line_in   = line_b;
            pos_in    = pos_next;
            origin_in = origin_b;
         end
         for (int i = 0; i < SLOTS; i++) slot_in[i] = new_slot[i];
         rem_in = new_count;
      end else if (rsp_xfer) begin
         for (int i = 0; i < SLOTS - 1; i++) slot_in[i] = slot_ff[i + 1];
         rem_in = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         len_ff      <= '0;
         prefix_ff   <= '0;
         line_ff     <= LINE_BITS'(1);
         pos_ff      <= '0;
         origin_ff   <= '0;
         rem_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         len_ff      <= len_in;
         prefix_ff   <= prefix_in;
         line_ff     <= line_in;
         pos_ff      <= pos_in;
         origin_ff   <= origin_in;
         rem_ff      <= rem_in;
      end
      if (req_xfer) begin
         in_byte_ff <= req_bus.source_byte;
         in_last_ff <= req_bus.end_of_source;
      end
      for (int i = 0; i < SLOTS; i++) slot_ff[i] <= slot_in[i];
   end

   assign rsp_bus.valid        = (rem_ff != 2'd0);
   assign rsp_bus.token_kind   = slot_ff[0].kind;
   assign rsp_bus.token_line   = slot_ff[0].line;
   assign rsp_bus.token_start  = slot_ff[0].start;
   assign rsp_bus.token_length = slot_ff[0].length;
   assign rsp_bus.bad_byte     = slot_ff[0].bad;
   assign rsp_bus.run_last     = slot_ff[0].last;

endmodule

`default_nettype wire

// ----- src/klex_checker.sv -----
// klex_checker: port-level checks on the token channel of the lexer
// depends on klex_pkg and assert_macros.svh; bound to keyword_token_lexer below
`default_nettype none
`include "assert_macros.svh"

module klex_checker import klex_pkg::*; (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire [KIND_BITS-1:0]   token_kind,
   input wire [LINE_BITS-1:0]   token_line,
   input wire [OFFSET_BITS-1:0] token_start,
   input wire [LEN_BITS-1:0]    token_length,
   input wire                   bad_byte,
   input wire                   run_last
);

   // a stalled token keeps its contents
   `KLEX_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_kind) && $stable(token_line) && $stable(token_start) && $stable(token_length) && $stable(run_last), "token changed under stall")

   // reset empties the result register
   `KLEX_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "token offered after reset")

   // the tokens of one byte come without gaps
   `KLEX_ASSERT(a_run_contiguous, rsp_valid && rsp_ready && !run_last |=> rsp_valid, "gap inside a token run")

   // an end token closes the run of its byte
   `KLEX_ASSERT(a_eof_last, rsp_valid && (token_kind == TK_EOF) |-> run_last && (token_length == '0), "end token not last in run")

   // the bad-byte flag only rides on end tokens
   `KLEX_ASSERT(a_bad_on_eof, rsp_valid && bad_byte |-> (token_kind == TK_EOF), "bad flag on a non-end token")

endmodule

bind keyword_token_lexer klex_checker u_klex_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .token_kind   (rsp_bus.token_kind),
   .token_line   (rsp_bus.token_line),
   .token_start  (rsp_bus.token_start),
   .token_length (rsp_bus.token_length),
   .bad_byte     (rsp_bus.bad_byte),
   .run_last     (rsp_bus.run_last)
);

`default_nettype wire
